// ===== design/masked_rgb_convolution_3x3_top_macros.svh =====
// Assertion macros for the masked RGB convolution block
`ifndef MASKED_RGB_CONVOLUTION_3X3_TOP_MACROS_SVH
`define MASKED_RGB_CONVOLUTION_3X3_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MRC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MRC_ASSERT(lbl, prop, msg)
`define MRC_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/mrc_pkg.sv =====
package mrc_pkg;

  localparam int MaxWidthDefault = 1024;
  localparam int CoeffFracDefault = 8;
  localparam int KernelSize = 3;
  localparam int NumTaps = KernelSize * KernelSize;
  localparam int ProdW = 25;
  localparam int SumW = 29;

  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_TOP = 3'd2;
  localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd4;

  localparam logic [10:0] WidthReset = 11'd1024;
  localparam logic [15:0] HeightReset = 16'd768;
  localparam logic [47:0] KernelTopReset = 48'd0;
  localparam logic [47:0] KernelMiddleReset = 48'd256;
  localparam logic [47:0] KernelBottomReset = 48'd0;

  typedef struct packed {
    logic       mask;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       in_masked;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [15:0] out_row;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        last_of_run;
    logic        frame_done;
  } out_item_t;

  // window slot (0..2) for a neighbor of a center, with edge clamping
  function automatic logic [1:0] win_idx(input logic signed [17:0] center,
                                         input logic [1:0] d,
                                         input logic signed [17:0] lim,
                                         input logic signed [17:0] base);
    logic signed [17:0] v;
    logic signed [17:0] t;
    v = center + 18'(d) - 18'sd1;
    if (v < 18'sd0) v = 18'sd0;
    if (v > lim) v = lim;
    t = v - base + 18'sd2;
    if (t < 18'sd0) t = 18'sd0;
    if (t > 18'sd2) t = 18'sd2;
    return t[1:0];
  endfunction

endpackage

// ===== design/mrc_cell.sv =====
module mrc_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  mrc_pkg::pix_t     col_in  [3],
  output mrc_pkg::pix_t     col_out [3]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) col_out[i] <= '0;
    end else if (shift) begin
      for (int i = 0; i < 3; i++) col_out[i] <= col_in[i];
    end
  end

endmodule

// ===== design/mrc_lane.sv =====
module mrc_lane #(
  parameter int COEFF_FRACTION_BITS = mrc_pkg::CoeffFracDefault
) (
  input  logic               clk,
  input  logic               adv,
  input  logic [7:0]         px   [mrc_pkg::NumTaps],
  input  logic signed [15:0] coef [mrc_pkg::NumTaps],
  output logic [7:0]         y
);

  logic signed [mrc_pkg::ProdW-1:0] prod [mrc_pkg::NumTaps];
  logic signed [mrc_pkg::SumW-1:0]  part [3];
  logic signed [mrc_pkg::SumW-1:0]  sum;
  logic signed [mrc_pkg::SumW-1:0]  q;

  assign sum = part[0] + part[1] + part[2];
  assign q = sum >>> COEFF_FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < mrc_pkg::NumTaps; i++)
        prod[i] <= mrc_pkg::ProdW'(coef[i] * $signed({1'b0, px[i]}));
      for (int j = 0; j < 3; j++)
        part[j] <= mrc_pkg::SumW'(prod[3*j]) + mrc_pkg::SumW'(prod[3*j+1])
                   + mrc_pkg::SumW'(prod[3*j+2]);
    end
  end

  always_comb begin
    if (sum < 0) y = 8'd0;
    else if (q > mrc_pkg::SumW'(255)) y = 8'd255;
    else y = q[7:0];
  end

endmodule

// ===== design/masked_rgb_convolution_3x3_top.sv =====
// Throughput: one item per cycle while res_stall is low; an item that causes n
// results holds the input until the single result issue slot feeding the filter
// pipeline has issued all of them.
// Reset (rst, synchronous): clears position, window and pipeline valids and
// loads register defaults; line stores are not cleared.
`include "masked_rgb_convolution_3x3_top_macros.svh"
module masked_rgb_convolution_3x3_top #(
  parameter int MAX_WIDTH = mrc_pkg::MaxWidthDefault,
  parameter int COEFF_FRACTION_BITS = mrc_pkg::CoeffFracDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  output logic                pix_stall,
  input  mrc_pkg::in_item_t   pix,
  output logic                res_valid,
  input  logic                res_stall,
  output mrc_pkg::out_item_t  res,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

  // configuration
  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [47:0] krow [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= mrc_pkg::WidthReset;
      image_height <= mrc_pkg::HeightReset;
      krow[0] <= mrc_pkg::KernelTopReset;
      krow[1] <= mrc_pkg::KernelMiddleReset;
      krow[2] <= mrc_pkg::KernelBottomReset;
    end else if (cfg_write) begin
      case (cfg_index)
        mrc_pkg::REG_IMAGE_WIDTH:   image_width <= cfg_data[10:0];
        mrc_pkg::REG_IMAGE_HEIGHT:  image_height <= cfg_data[15:0];
        mrc_pkg::REG_KERNEL_TOP:    krow[0] <= cfg_data;
        mrc_pkg::REG_KERNEL_MIDDLE: krow[1] <= cfg_data;
        mrc_pkg::REG_KERNEL_BOTTOM: krow[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // position and effective size
  logic [WW-1:0] w_ext;
  logic [WW-1:0] w_eff;
  logic [AW-1:0] wm1;
  logic [15:0]   hm1;
  logic [AW-1:0] col;
  logic [15:0]   row;
  logic [AW-1:0] c_now;
  logic [15:0]   r_now;
  logic          lc_now;
  logic          lr_now;
  logic          accept;

  assign w_ext = WW'(image_width);
  always_comb begin
    w_eff = w_ext;
    if (w_ext == '0) w_eff = WW'(1);
    if (w_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
  end
  assign wm1 = AW'(w_eff - WW'(1));
  assign hm1 = (image_height == 16'd0) ? 16'd0 : image_height - 16'd1;
  assign c_now = (col > wm1) ? wm1 : col;
  assign r_now = (row > hm1) ? hm1 : row;
  assign lc_now = (c_now == wm1);
  assign lr_now = (r_now == hm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (lc_now) begin
        col <= '0;
        row <= lr_now ? 16'd0 : r_now + 16'd1;
      end else begin
        col <= c_now + AW'(1);
        row <= r_now;
      end
    end
  end

  // line stores, read at accept, written when the item enters the window
  mrc_pkg::pix_t store_older [MAX_WIDTH];
  mrc_pkg::pix_t store_newer [MAX_WIDTH];
  mrc_pkg::pix_t rd_older;
  mrc_pkg::pix_t rd_newer;
  mrc_pkg::pix_t last_newer;
  mrc_pkg::pix_t last_px;
  mrc_pkg::pix_t older_eff;
  mrc_pkg::pix_t newer_eff;

  logic          s1_valid;
  logic          s1_adv;
  logic          byp;
  mrc_pkg::pix_t s1_px;
  logic [AW-1:0] s1_c;
  logic [15:0]   s1_r;
  logic [AW-1:0] s1_wm1;
  logic [15:0]   s1_hm1;
  logic          s1_lc;
  logic          s1_lr;

  assign accept = pix_valid && !pix_stall;
  assign pix_stall = s1_valid && !s1_adv;
  assign older_eff = byp ? last_newer : rd_older;
  assign newer_eff = byp ? last_px : rd_newer;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_older <= store_older[c_now];
      rd_newer <= store_newer[c_now];
    end
    if (s1_adv) begin
      store_older[s1_c] <= newer_eff;
      store_newer[s1_c] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (accept) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
    end
    if (s1_adv) begin
      last_newer <= newer_eff;
      last_px <= s1_px;
    end
    if (accept) begin
      byp <= s1_valid && (s1_c == c_now);
      s1_px <= '{mask: pix.in_masked, blue: pix.in_blue, green: pix.in_green,
                 red: pix.in_red};
      s1_c <= c_now;
      s1_r <= r_now;
      s1_wm1 <= wm1;
      s1_hm1 <= hm1;
      s1_lc <= lc_now;
      s1_lr <= lr_now;
    end
  end

  // window: three column cells, newest in slot 2
  mrc_pkg::pix_t col_new [3];
  mrc_pkg::pix_t win [3][3];
  mrc_pkg::pix_t cell_out [3][3];

  assign col_new[0] = older_eff;
  assign col_new[1] = newer_eff;
  assign col_new[2] = s1_px;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    if (k == 2) begin : g_head
      mrc_cell u_cell (.clk(clk), .rst(rst), .shift(s1_adv), .col_in(col_new),
                       .col_out(cell_out[k]));
    end else begin : g_body
      mrc_cell u_cell (.clk(clk), .rst(rst), .shift(s1_adv),
                       .col_in(cell_out[k+1]), .col_out(cell_out[k]));
    end
    for (genvar i = 0; i < 3; i++) begin : g_row
      assign win[i][k] = cell_out[k][i];
    end
  end

  // result issue
  logic [3:0]    pend;
  logic [3:0]    sel;
  logic [3:0]    rem;
  logic [AW-1:0] e_c;
  logic [15:0]   e_r;
  logic [AW-1:0] e_wm1;
  logic [15:0]   e_hm1;
  logic          e_done_ok;
  logic          adv;
  logic          issue;
  logic          e_free;
  logic [AW-1:0] cc;
  logic [15:0]   cr;
  logic [1:0]    wr [3];
  logic [1:0]    wc [3];
  logic [1:0]    sr;
  logic [1:0]    sc;

  assign adv = !res_valid || !res_stall;
  assign issue = adv && (pend != 4'd0);
  assign sel = pend & (~pend + 4'd1);
  assign rem = pend & ~sel;
  assign e_free = (pend == 4'd0) || (issue && (rem == 4'd0));
  assign s1_adv = s1_valid && e_free;
  assign cc = e_c - AW'(sel[0] | sel[2]);
  assign cr = e_r - 16'(sel[0] | sel[1]);
  assign sr = (sel[0] | sel[1]) ? 2'd1 : 2'd2;
  assign sc = (sel[0] | sel[2]) ? 2'd1 : 2'd2;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      wr[d] = mrc_pkg::win_idx($signed(18'(cr)), 2'(d), $signed(18'(e_hm1)),
                               $signed(18'(e_r)));
      wc[d] = mrc_pkg::win_idx($signed(18'(cc)), 2'(d), $signed(18'(e_wm1)),
                               $signed(18'(e_c)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 4'd0;
    end else if (s1_adv) begin
      pend <= {s1_lr & s1_lc, s1_lr & (s1_c != '0),
               (s1_r != 16'd0) & s1_lc, (s1_r != 16'd0) & (s1_c != '0)};
    end else if (issue) begin
      pend <= rem;
    end
    if (s1_adv) begin
      e_c <= s1_c;
      e_r <= s1_r;
      e_wm1 <= s1_wm1;
      e_hm1 <= s1_hm1;
      e_done_ok <= s1_lr & s1_lc;
    end
  end

  // filter pipeline
  logic          v1;
  logic          v2;
  logic          v3;
  logic [7:0]    p1_r [mrc_pkg::NumTaps];
  logic [7:0]    p1_g [mrc_pkg::NumTaps];
  logic [7:0]    p1_b [mrc_pkg::NumTaps];
  mrc_pkg::pix_t p1_ctr;
  mrc_pkg::pix_t p2_ctr;
  mrc_pkg::pix_t p3_ctr;
  logic [AW-1:0] p1_cc;
  logic [AW-1:0] p2_cc;
  logic [AW-1:0] p3_cc;
  logic [15:0]   p1_cr;
  logic [15:0]   p2_cr;
  logic [15:0]   p3_cr;
  logic [1:0]    p1_fl;
  logic [1:0]    p2_fl;
  logic [1:0]    p3_fl;
  logic signed [15:0] coef [mrc_pkg::NumTaps];
  logic [7:0]    y_r;
  logic [7:0]    y_g;
  logic [7:0]    y_b;

  for (genvar t = 0; t < mrc_pkg::NumTaps; t++) begin : g_coef
    assign coef[t] = $signed(krow[t/3][16*(t%3) +: 16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      res_valid <= v3;
    end
    if (adv) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          p1_r[3*dy+dx] <= win[wr[dy]][wc[dx]].red;
          p1_g[3*dy+dx] <= win[wr[dy]][wc[dx]].green;
          p1_b[3*dy+dx] <= win[wr[dy]][wc[dx]].blue;
        end
      end
      p1_ctr <= win[sr][sc];
      p1_cc <= cc;
      p1_cr <= cr;
      p1_fl <= {rem == 4'd0, e_done_ok & (rem == 4'd0)};
      p2_ctr <= p1_ctr;
      p2_cc <= p1_cc;
      p2_cr <= p1_cr;
      p2_fl <= p1_fl;
      p3_ctr <= p2_ctr;
      p3_cc <= p2_cc;
      p3_cr <= p2_cr;
      p3_fl <= p2_fl;
      res.out_column <= 10'(p3_cc);
      res.out_row <= p3_cr;
      res.last_of_run <= p3_fl[1];
      res.frame_done <= p3_fl[0];
      if (p3_ctr.mask) begin
        res.out_red <= y_r;
        res.out_green <= y_g;
        res.out_blue <= y_b;
      end else begin
        res.out_red <= p3_ctr.red;
        res.out_green <= p3_ctr.green;
        res.out_blue <= p3_ctr.blue;
      end
    end
  end

  // lane outputs come from the last lane stage, in step with p3
  logic [7:0] l_r;
  logic [7:0] l_g;
  logic [7:0] l_b;

  mrc_lane #(.COEFF_FRACTION_BITS(COEFF_FRACTION_BITS)) u_lane_r (
    .clk(clk), .adv(adv), .px(p1_r), .coef(coef), .y(l_r));
  mrc_lane #(.COEFF_FRACTION_BITS(COEFF_FRACTION_BITS)) u_lane_g (
    .clk(clk), .adv(adv), .px(p1_g), .coef(coef), .y(l_g));
  mrc_lane #(.COEFF_FRACTION_BITS(COEFF_FRACTION_BITS)) u_lane_b (
    .clk(clk), .adv(adv), .px(p1_b), .coef(coef), .y(l_b));

  assign y_r = l_r;
  assign y_g = l_g;
  assign y_b = l_b;

  `MRC_ASSERT(a_s1_free, s1_adv |-> (pend == 4'd0 || (issue && $onehot(pend))), "s1 left early")
  `MRC_ASSERT(a_accept_moves_s1, (accept && s1_valid) |-> s1_adv, "item accepted over held item")
  `MRC_NEVER(a_done_is_last, res_valid && res.frame_done && !res.last_of_run, "done not last")

endmodule
